FILE: sv/sss_pkg.sv
package sss_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int FRAME_BITS  = 16;
  localparam int POS_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int STORE_W     = 4 * DIGIT_COUNT;
  localparam int BIT_W       = $clog2(FRAME_BITS);

  localparam logic [0:0] REQ_LOAD    = 1'b0;
  localparam logic [0:0] REQ_REFRESH = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] number_value;
  } sss_in_t;

  typedef struct packed {
    logic       serial_bit;
    logic [1:0] digit_position;
    logic       latch_after;
    logic       last_bit;
  } sss_out_t;

  typedef struct packed {
    logic load;
    logic start;
    logic emit;
  } sss_cmd_t;

  typedef struct packed {
    logic last_bit;
  } sss_sts_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } sss_state_e;

  // Active-low segment pattern; anything above nine blanks the digit
  function automatic logic [7:0] seg_pattern(input logic [3:0] d);
    logic [7:0] pat;
    unique case (d)
      4'd0:    pat = 8'hC0;
      4'd1:    pat = 8'hF9;
      4'd2:    pat = 8'hA4;
      4'd3:    pat = 8'hB0;
      4'd4:    pat = 8'h99;
      4'd5:    pat = 8'h92;
      4'd6:    pat = 8'h82;
      4'd7:    pat = 8'hF8;
      4'd8:    pat = 8'h80;
      4'd9:    pat = 8'h90;
      default: pat = 8'hFF;
    endcase
    return pat;
  endfunction

  // Position-select byte: upper nibble forced high for the first four positions
  function automatic logic [7:0] select_byte(input logic [POS_W-1:0] p);
    logic [7:0] one;
    one = 8'h01 << p;
    if (int'(p) < 4) begin
      one = one | 8'hF0;
    end
    return one;
  endfunction

endpackage

FILE: sv/sss_datapath.sv
module sss_datapath import sss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sss_cmd_t cmd_i,
  input  sss_in_t  in_data_i,
  output sss_sts_t sts_o,
  output sss_out_t out_data_o
);

  localparam logic [BIT_W-1:0] FRAME_LAST = BIT_W'(FRAME_BITS - 1);
  localparam logic [POS_W-1:0] LAST_POS   = POS_W'(DIGIT_COUNT - 1);

  logic [STORE_W-1:0]    store_q, store_d;
  logic [FRAME_BITS-1:0] frame_q, frame_d;
  logic [BIT_W-1:0]      bit_q, bit_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  sss_out_t              out_q, out_d;

  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  ones_w;
  logic [3:0]  ones;
  logic [STORE_W-1:0] bcd;
  logic [POS_W-1:0]   pos_nxt;

  // Hundreds by compare, tens by reciprocal multiply (205/2048), ones by remainder
  always_comb begin
    priority if (in_data_i.number_value >= 8'd200) begin
      hund = 2'd2;
      rem  = 7'(in_data_i.number_value - 8'd200);
    end else if (in_data_i.number_value >= 8'd100) begin
      hund = 2'd1;
      rem  = 7'(in_data_i.number_value - 8'd100);
    end else begin
      hund = 2'd0;
      rem  = in_data_i.number_value[6:0];
    end
    prod   = 15'(rem) * 15'd205;
    tens   = prod[14:11];
    ones_w = 7'(rem - 7'(tens) * 7'd10);
    ones   = ones_w[3:0];
  end

  // Ones digit at the last position; digits that do not fit are dropped
  always_comb begin
    int k;
    bcd = '0;
    for (int q = 0; q < DIGIT_COUNT; q++) begin
      k = DIGIT_COUNT - 1 - q;
      if (k == 0) begin
        bcd[4*q +: 4] = ones;
      end else if (k == 1) begin
        bcd[4*q +: 4] = tens;
      end else if (k == 2) begin
        bcd[4*q +: 4] = {2'b00, hund};
      end
    end
  end

  function automatic logic [FRAME_BITS-1:0] frame_for(input logic [STORE_W-1:0] s,
                                                      input logic [POS_W-1:0] p);
    logic [3:0] nib;
    nib = 4'd0;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (p == POS_W'(i)) begin
        nib = s[4*i +: 4];
      end
    end
    return {seg_pattern(nib), select_byte(p)};
  endfunction

  assign pos_nxt = pos_q + POS_W'(1);

  always_comb begin
    store_d = store_q;
    frame_d = frame_q;
    bit_d   = bit_q;
    pos_d   = pos_q;
    out_d   = out_q;
    if (cmd_i.load) begin
      store_d = bcd;
    end
    if (cmd_i.start) begin
      frame_d = frame_for(store_q, '0);
      bit_d   = '0;
      pos_d   = '0;
    end
    if (cmd_i.emit) begin
      out_d.serial_bit     = frame_q[FRAME_BITS-1];
      out_d.digit_position = 2'(pos_q);
      out_d.latch_after    = (bit_q == FRAME_LAST);
      out_d.last_bit       = (bit_q == FRAME_LAST) && (pos_q == LAST_POS);
      if (bit_q == FRAME_LAST) begin
        frame_d = frame_for(store_q, pos_nxt);
        bit_d   = '0;
        pos_d   = pos_nxt;
      end else begin
        frame_d = frame_q << 1;
        bit_d   = bit_q + BIT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      frame_q <= '0;
      bit_q   <= '0;
      pos_q   <= '0;
    end else begin
      store_q <= store_d;
      frame_q <= frame_d;
      bit_q   <= bit_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign sts_o.last_bit = (bit_q == FRAME_LAST) && (pos_q == LAST_POS);
  assign out_data_o     = out_q;

endmodule

FILE: sv/sss_ctrl.sv
module sss_ctrl import sss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     req_type_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  sss_sts_t sts_i,
  output sss_cmd_t cmd_o
);

  sss_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       can_emit;

  assign can_emit = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (req_type_i == REQ_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (can_emit) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_bit) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = cmd_o.emit ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (state_q == ST_SCAN) && !(out_valid_q && out_stall_i))
    else $error("beat pushed over a held beat");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && sts_i.last_bit) |=> (state_q == ST_IDLE) && out_valid_q)
    else $error("scan did not end after last bit");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load || cmd_o.start) |-> (state_q == ST_IDLE) && !(cmd_o.load && cmd_o.start))
    else $error("load or start outside idle");
`endif

endmodule

FILE: sv/seven_segment_serial_scan.sv
// Channel | Direction | Handshake                   | Beat
// --------+-----------+-----------------------------+----------------------------------
// in      | input     | in_valid_i / in_stall_o     | sss_in_t: req_type, number_value
// out     | output    | out_valid_o / out_stall_i   | sss_out_t: one serial bit each
//
// A load beat is accepted and the digit store updated at the same clock edge.
// A refresh is accepted, then gives 16*DIGIT_COUNT beats (64 here), one a cycle unless
// the output stalls, paced by the frame bit counter and position counter in the datapath.
// The next beat in is taken the cycle after the last refresh bit enters the output register.
// A stall on the output holds the output register and freezes the scan counters.
// Reset clears the digit store (display shows 0000) and returns the controller to idle.
module seven_segment_serial_scan import sss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sss_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sss_out_t out_data_o
);

  sss_cmd_t cmd;
  sss_sts_t sts;

  // Sequence loads and scans; own the output valid flag
  sss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (in_data_i.req_type),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold the BCD store, shift the frame out MSB first, register each beat
  sss_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
